### rtl/core/rigid_body_euler_step_core_assert.svh
// Assertion macros for the rigid body step core RTL.
`ifndef RIGID_BODY_EULER_STEP_CORE_ASSERT_SVH
`define RIGID_BODY_EULER_STEP_CORE_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define RBES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define RBES_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/rbes_pkg.sv
// Types, codes and microcode program of the rigid body step core.
`timescale 1ns / 1ps

package rbes_pkg;

    localparam int DATA_W        = 32;
    localparam int DT_W          = 17;
    localparam int KIND_W        = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int PROD_W        = 2 * DATA_W + 1;
    localparam int WIDE_W        = PROD_W + 2;
    localparam int FRAC_BITS_DEF = 16;
    localparam int STATIC_RATIO  = 200;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_FORCE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TORQUE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LIN    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OFF    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_MASS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_INERTIA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_X       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 2'd3;

    typedef logic [3:0] asel_t;
    typedef logic [2:0] bsel_t;
    typedef logic [2:0] wb_t;
    typedef logic [3:0] dst_t;
    typedef logic [4:0] uaddr_t;

    // multiplier operand A / add source
    localparam asel_t A_VX   = 4'd0;
    localparam asel_t A_VY   = 4'd1;
    localparam asel_t A_AX   = 4'd2;
    localparam asel_t A_AY   = 4'd3;
    localparam asel_t A_TQIN = 4'd4;
    localparam asel_t A_TQS  = 4'd5;
    localparam asel_t A_FX   = 4'd6;
    localparam asel_t A_FY   = 4'd7;
    localparam asel_t A_T0   = 4'd8;
    localparam asel_t A_T1   = 4'd9;
    localparam asel_t A_T2   = 4'd10;
    localparam asel_t A_VELX = 4'd11;
    localparam asel_t A_VELY = 4'd12;
    localparam asel_t A_SPIN = 4'd13;

    // multiplier operand B
    localparam bsel_t B_IM = 3'd0;
    localparam bsel_t B_II = 3'd1;
    localparam bsel_t B_DT = 3'd2;
    localparam bsel_t B_VX = 3'd3;
    localparam bsel_t B_VY = 3'd4;

    // writeback operations
    localparam wb_t WB_NONE   = 3'd0;
    localparam wb_t WB_ADD_IN = 3'd1;  // dst = sat(dst + A)
    localparam wb_t WB_ACC    = 3'd2;  // dst = sat(dst + P >>> F)
    localparam wb_t WB_SAT    = 3'd3;  // dst = sat(P >>> F)
    localparam wb_t WB_HOLD   = 3'd4;  // H = P
    localparam wb_t WB_DIFF   = 3'd5;  // dst = sat((H - P) >>> F)

    // writeback destinations
    localparam dst_t D_FX   = 4'd0;
    localparam dst_t D_FY   = 4'd1;
    localparam dst_t D_TQ   = 4'd2;
    localparam dst_t D_VELX = 4'd3;
    localparam dst_t D_VELY = 4'd4;
    localparam dst_t D_POSX = 4'd5;
    localparam dst_t D_POSY = 4'd6;
    localparam dst_t D_SPIN = 4'd7;
    localparam dst_t D_ANG  = 4'd8;
    localparam dst_t D_T0   = 4'd9;
    localparam dst_t D_T1   = 4'd10;
    localparam dst_t D_T2   = 4'd11;

    localparam logic JC_NONE   = 1'b0;
    localparam logic JC_STATIC = 1'b1;

    // program entry points
    localparam uaddr_t UA_FORCE  = 5'd0;
    localparam uaddr_t UA_TORQUE = 5'd2;
    localparam uaddr_t UA_LIN    = 5'd3;
    localparam uaddr_t UA_OFF    = 5'd6;
    localparam uaddr_t UA_UPD    = 5'd13;
    localparam uaddr_t UA_DONE   = 5'd23;

    typedef struct packed {
        logic   mul_en;
        asel_t  asel;
        bsel_t  bsel;
        wb_t    wb;
        dst_t   dst;
        logic   clr;
        logic   jc;
        uaddr_t target;
        logic   last;
    } uword_t;

    localparam uword_t UW_IDLE = '0;

    typedef struct packed {
        logic   start;
        logic   load;
        uword_t w;
    } seq_ctl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] angle;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic signed [DATA_W-1:0] spin;
        logic                     is_static;
    } result_t;

    function automatic uword_t mk(logic m, asel_t a, bsel_t b, wb_t op, dst_t d,
                                  logic c, logic j, uaddr_t t, logic l);
        uword_t u;
        u.mul_en = m;
        u.asel   = a;
        u.bsel   = b;
        u.wb     = op;
        u.dst    = d;
        u.clr    = c;
        u.jc     = j;
        u.target = t;
        u.last   = l;
        return u;
    endfunction

    function automatic uaddr_t entry(logic [KIND_W-1:0] kind);
        case (kind)
            KIND_FORCE:  return UA_FORCE;
            KIND_TORQUE: return UA_TORQUE;
            KIND_LIN:    return UA_LIN;
            KIND_OFF:    return UA_OFF;
            KIND_UPDATE: return UA_UPD;
            default:     return UA_DONE;
        endcase
    endfunction

    // Writeback of a word acts on the product issued by the word before it.
    function automatic uword_t ucode(uaddr_t a);
        case (a)
            UA_FORCE:       return mk(0, A_VX,   B_IM, WB_ADD_IN, D_FX,   0, JC_NONE,   UA_DONE, 0);
            UA_FORCE + 5'd1:return mk(0, A_VY,   B_IM, WB_ADD_IN, D_FY,   0, JC_NONE,   UA_DONE, 1);
            UA_TORQUE:      return mk(0, A_TQIN, B_IM, WB_ADD_IN, D_TQ,   0, JC_NONE,   UA_DONE, 1);
            UA_LIN:         return mk(1, A_VX,   B_IM, WB_NONE,   D_FX,   0, JC_STATIC, UA_DONE, 0);
            UA_LIN + 5'd1:  return mk(1, A_VY,   B_IM, WB_ACC,    D_VELX, 0, JC_NONE,   UA_DONE, 0);
            UA_LIN + 5'd2:  return mk(0, A_VX,   B_IM, WB_ACC,    D_VELY, 0, JC_NONE,   UA_DONE, 1);
            UA_OFF:         return mk(1, A_VX,   B_IM, WB_NONE,   D_FX,   0, JC_STATIC, UA_DONE, 0);
            UA_OFF + 5'd1:  return mk(1, A_VY,   B_IM, WB_ACC,    D_VELX, 0, JC_NONE,   UA_DONE, 0);
            UA_OFF + 5'd2:  return mk(1, A_AX,   B_VY, WB_ACC,    D_VELY, 0, JC_NONE,   UA_DONE, 0);
            UA_OFF + 5'd3:  return mk(1, A_AY,   B_VX, WB_HOLD,   D_FX,   0, JC_NONE,   UA_DONE, 0);
            UA_OFF + 5'd4:  return mk(0, A_VX,   B_IM, WB_DIFF,   D_T0,   0, JC_NONE,   UA_DONE, 0);
            UA_OFF + 5'd5:  return mk(1, A_T0,   B_II, WB_NONE,   D_FX,   0, JC_NONE,   UA_DONE, 0);
            UA_OFF + 5'd6:  return mk(0, A_VX,   B_IM, WB_ACC,    D_SPIN, 0, JC_NONE,   UA_DONE, 1);
            UA_UPD:         return mk(1, A_FX,   B_IM, WB_NONE,   D_FX,   0, JC_STATIC, UA_DONE, 0);
            UA_UPD + 5'd1:  return mk(1, A_FY,   B_IM, WB_SAT,    D_T0,   0, JC_NONE,   UA_DONE, 0);
            UA_UPD + 5'd2:  return mk(1, A_TQS,  B_II, WB_SAT,    D_T1,   0, JC_NONE,   UA_DONE, 0);
            UA_UPD + 5'd3:  return mk(1, A_T0,   B_DT, WB_SAT,    D_T2,   0, JC_NONE,   UA_DONE, 0);
            UA_UPD + 5'd4:  return mk(1, A_T1,   B_DT, WB_ACC,    D_VELX, 0, JC_NONE,   UA_DONE, 0);
            UA_UPD + 5'd5:  return mk(1, A_T2,   B_DT, WB_ACC,    D_VELY, 0, JC_NONE,   UA_DONE, 0);
            UA_UPD + 5'd6:  return mk(1, A_VELX, B_DT, WB_ACC,    D_SPIN, 0, JC_NONE,   UA_DONE, 0);
            UA_UPD + 5'd7:  return mk(1, A_VELY, B_DT, WB_ACC,    D_POSX, 0, JC_NONE,   UA_DONE, 0);
            UA_UPD + 5'd8:  return mk(1, A_SPIN, B_DT, WB_ACC,    D_POSY, 0, JC_NONE,   UA_DONE, 0);
            UA_UPD + 5'd9:  return mk(0, A_VX,   B_IM, WB_ACC,    D_ANG,  1, JC_NONE,   UA_DONE, 1);
            default:        return mk(0, A_VX,   B_IM, WB_NONE,   D_FX,   0, JC_NONE,   UA_DONE, 1);
        endcase
    endfunction

endpackage

### rtl/core/rbes_if.sv
// Item and result channel interfaces of the rigid body step core.
`timescale 1ns / 1ps

interface rbes_in_if import rbes_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] vec_x;
    logic signed [DATA_W-1:0] vec_y;
    logic signed [DATA_W-1:0] torque_value;
    logic signed [DATA_W-1:0] arm_x;
    logic signed [DATA_W-1:0] arm_y;
    logic [DT_W-1:0]          step_time;

    modport source (output valid, kind, vec_x, vec_y, torque_value, arm_x, arm_y,
                    step_time, input ready);
    modport sink   (input valid, kind, vec_x, vec_y, torque_value, arm_x, arm_y,
                    step_time, output ready);
endinterface

interface rbes_out_if import rbes_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] angle;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] spin;
    logic                     is_static;

    modport source (output valid, pos_x, pos_y, angle, vel_x, vel_y, spin, is_static,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, angle, vel_x, vel_y, spin, is_static,
                    output ready);
endinterface

### rtl/core/rbes_seq.sv
// Microcode sequencer: step counter, program lookup, jumps and result handshake.
`timescale 1ns / 1ps
`include "rigid_body_euler_step_core_assert.svh"

module rbes_seq import rbes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] in_kind,
    input  logic              out_ready,
    output logic              out_valid,
    input  logic              stat,
    output seq_ctl_t          ctl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    uaddr_t     upc_reg, upc_next;
    logic       out_valid_reg, out_valid_next;
    uword_t     w;
    logic       accept;

    always_comb
    begin
        w        = ucode(upc_reg);
        in_ready = (state_reg == ST_IDLE);
        accept   = in_valid && in_ready;

        ctl.start = accept;
        ctl.load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
        ctl.w     = (state_reg == ST_RUN) ? w : UW_IDLE;

        state_next = state_reg;
        upc_next   = upc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    upc_next   = entry(in_kind);
                end
            end
            ST_RUN:
            begin
                if (w.jc == JC_STATIC && stat)
                    upc_next = w.target;
                else if (w.last)
                    state_next = ST_DONE;
                else
                    upc_next = upc_reg + 5'd1;
            end
            ST_DONE:
            begin
                if (ctl.load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (ctl.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            upc_reg       <= UA_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `RBES_ASSERT_NEXT(a_accept_runs, accept, state_reg == ST_RUN, "accepted word did not start program")
    `RBES_ASSERT(a_upc_range, (state_reg == ST_RUN) |-> (upc_reg <= UA_DONE), "step counter out of program")
    `RBES_ASSERT(a_valid_from_done, $rose(out_valid_reg) |-> $past(state_reg == ST_DONE), "result raised outside done")

endmodule

### rtl/core/rbes_dp.sv
// Datapath: body state, shared multiplier, saturating writeback and result register.
`timescale 1ns / 1ps

module rbes_dp import rbes_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  seq_ctl_t                 ctl,
    input  logic signed [DATA_W-1:0] vec_x,
    input  logic signed [DATA_W-1:0] vec_y,
    input  logic signed [DATA_W-1:0] torque_value,
    input  logic signed [DATA_W-1:0] arm_x,
    input  logic signed [DATA_W-1:0] arm_y,
    input  logic [DT_W-1:0]          step_time,
    output logic                     stat,
    output result_t                  res
);

    localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] STATIC_LIMIT =
        DATA_W'(((64'd1 << FRAC_BITS) + 64'(STATIC_RATIO) - 64'd1) / 64'(STATIC_RATIO));
    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic [DATA_W-1:0]        im_reg, im_next, ii_reg, ii_next;
    logic signed [DATA_W-1:0] posx_reg, posx_next, posy_reg, posy_next;
    logic signed [DATA_W-1:0] velx_reg, velx_next, vely_reg, vely_next;
    logic signed [DATA_W-1:0] ang_reg, ang_next, spin_reg, spin_next;
    logic signed [DATA_W-1:0] fx_reg, fx_next, fy_reg, fy_next, tq_reg, tq_next;
    logic signed [DATA_W-1:0] t0_reg, t0_next, t1_reg, t1_next, t2_reg, t2_next;
    logic signed [DATA_W-1:0] vx_reg, vx_next, vy_reg, vy_next, tqi_reg, tqi_next;
    logic signed [DATA_W-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [DT_W-1:0]          dt_reg, dt_next;
    logic signed [PROD_W-1:0] p_reg, p_next, h_reg, h_next;
    result_t                  res_reg, res_next;

    logic signed [DATA_W-1:0] opa, dst_val, wr_val;
    logic signed [DATA_W:0]   opb;
    logic signed [PROD_W-1:0] prod;
    logic signed [WIDE_W-1:0] p_ext, h_ext, wide, shifted, sum, dst_ext, opa_ext;
    logic                     wr_en;

    assign stat = (im_reg < STATIC_LIMIT);

    always_comb
    begin
        case (ctl.w.asel)
            A_VX:    opa = vx_reg;
            A_VY:    opa = vy_reg;
            A_AX:    opa = ax_reg;
            A_AY:    opa = ay_reg;
            A_TQIN:  opa = tqi_reg;
            A_TQS:   opa = tq_reg;
            A_FX:    opa = fx_reg;
            A_FY:    opa = fy_reg;
            A_T0:    opa = t0_reg;
            A_T1:    opa = t1_reg;
            A_T2:    opa = t2_reg;
            A_VELX:  opa = velx_reg;
            A_VELY:  opa = vely_reg;
            A_SPIN:  opa = spin_reg;
            default: opa = '0;
        endcase

        case (ctl.w.bsel)
            B_IM:    opb = {1'b0, im_reg};
            B_II:    opb = {1'b0, ii_reg};
            B_DT:    opb = {{(DATA_W+1-DT_W){1'b0}}, dt_reg};
            B_VX:    opb = {vx_reg[DATA_W-1], vx_reg};
            B_VY:    opb = {vy_reg[DATA_W-1], vy_reg};
            default: opb = '0;
        endcase

        prod = opa * opb;

        case (ctl.w.dst)
            D_FX:    dst_val = fx_reg;
            D_FY:    dst_val = fy_reg;
            D_TQ:    dst_val = tq_reg;
            D_VELX:  dst_val = velx_reg;
            D_VELY:  dst_val = vely_reg;
            D_POSX:  dst_val = posx_reg;
            D_POSY:  dst_val = posy_reg;
            D_SPIN:  dst_val = spin_reg;
            D_ANG:   dst_val = ang_reg;
            D_T0:    dst_val = t0_reg;
            D_T1:    dst_val = t1_reg;
            D_T2:    dst_val = t2_reg;
            default: dst_val = '0;
        endcase

        p_ext   = {{(WIDE_W-PROD_W){p_reg[PROD_W-1]}}, p_reg};
        h_ext   = {{(WIDE_W-PROD_W){h_reg[PROD_W-1]}}, h_reg};
        dst_ext = {{(WIDE_W-DATA_W){dst_val[DATA_W-1]}}, dst_val};
        opa_ext = {{(WIDE_W-DATA_W){opa[DATA_W-1]}}, opa};
        wide    = (ctl.w.wb == WB_DIFF) ? (h_ext - p_ext) : p_ext;
        shifted = wide >>> FRAC_BITS;

        wr_en = 1'b1;
        case (ctl.w.wb)
            WB_ADD_IN: sum = dst_ext + opa_ext;
            WB_ACC:    sum = dst_ext + shifted;
            WB_SAT:    sum = shifted;
            WB_DIFF:   sum = shifted;
            default:
            begin
                sum   = '0;
                wr_en = 1'b0;
            end
        endcase

        if ((&sum[WIDE_W-1:DATA_W-1]) || !(|sum[WIDE_W-1:DATA_W-1]))
            wr_val = sum[DATA_W-1:0];
        else
            wr_val = sum[WIDE_W-1] ? S_MIN : S_MAX;
    end

    always_comb
    begin
        im_next   = im_reg;
        ii_next   = ii_reg;
        posx_next = posx_reg;
        posy_next = posy_reg;
        velx_next = velx_reg;
        vely_next = vely_reg;
        ang_next  = ang_reg;
        spin_next = spin_reg;
        fx_next   = fx_reg;
        fy_next   = fy_reg;
        tq_next   = tq_reg;
        t0_next   = t0_reg;
        t1_next   = t1_reg;
        t2_next   = t2_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_RECIP_MASS:    im_next   = cfg_data;
                REG_RECIP_INERTIA: ii_next   = cfg_data;
                REG_START_X:       posx_next = cfg_data;
                REG_START_Y:       posy_next = cfg_data;
                default:           im_next   = im_reg;
            endcase
        end

        if (wr_en)
        begin
            case (ctl.w.dst)
                D_FX:    fx_next   = wr_val;
                D_FY:    fy_next   = wr_val;
                D_TQ:    tq_next   = wr_val;
                D_VELX:  velx_next = wr_val;
                D_VELY:  vely_next = wr_val;
                D_POSX:  posx_next = wr_val;
                D_POSY:  posy_next = wr_val;
                D_SPIN:  spin_next = wr_val;
                D_ANG:   ang_next  = wr_val;
                D_T0:    t0_next   = wr_val;
                D_T1:    t1_next   = wr_val;
                D_T2:    t2_next   = wr_val;
                default: t0_next   = t0_reg;
            endcase
        end

        if (ctl.w.clr)
        begin
            fx_next = '0;
            fy_next = '0;
            tq_next = '0;
        end

        p_next = ctl.w.mul_en ? prod : p_reg;
        h_next = (ctl.w.wb == WB_HOLD) ? p_reg : h_reg;

        vx_next  = ctl.start ? vec_x : vx_reg;
        vy_next  = ctl.start ? vec_y : vy_reg;
        tqi_next = ctl.start ? torque_value : tqi_reg;
        ax_next  = ctl.start ? arm_x : ax_reg;
        ay_next  = ctl.start ? arm_y : ay_reg;
        dt_next  = ctl.start ? step_time : dt_reg;

        res_next           = res_reg;
        if (ctl.load)
        begin
            res_next.pos_x     = posx_reg;
            res_next.pos_y     = posy_reg;
            res_next.angle     = ang_reg;
            res_next.vel_x     = velx_reg;
            res_next.vel_y     = vely_reg;
            res_next.spin      = spin_reg;
            res_next.is_static = stat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            im_reg   <= ONE_FX;
            ii_reg   <= ONE_FX;
            posx_reg <= '0;
            posy_reg <= '0;
            velx_reg <= '0;
            vely_reg <= '0;
            ang_reg  <= '0;
            spin_reg <= '0;
            fx_reg   <= '0;
            fy_reg   <= '0;
            tq_reg   <= '0;
        end
        else
        begin
            im_reg   <= im_next;
            ii_reg   <= ii_next;
            posx_reg <= posx_next;
            posy_reg <= posy_next;
            velx_reg <= velx_next;
            vely_reg <= vely_next;
            ang_reg  <= ang_next;
            spin_reg <= spin_next;
            fx_reg   <= fx_next;
            fy_reg   <= fy_next;
            tq_reg   <= tq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        t2_reg  <= t2_next;
        p_reg   <= p_next;
        h_reg   <= h_next;
        vx_reg  <= vx_next;
        vy_reg  <= vy_next;
        tqi_reg <= tqi_next;
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        dt_reg  <= dt_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

### rtl/core/rigid_body_euler_step_core.sv
// Top level of the 2D rigid body semi-implicit Euler step core.
`timescale 1ns / 1ps

// Usage:
//   items   : valid/ready channel, one word per command (force, torque, linear
//             impulse, offset impulse, update); a word is taken only while the
//             core is idle.
//   results : valid/ready channel, one word per item with the body state after it.
//   cfg_*   : write-only registers, index 0 inverse mass, 1 inverse inertia,
//             2 start_x, 3 start_y (also loads position); write only while idle.
// Timing: a word runs N microcode steps on one shared 32x33 multiplier, then
//   the result register is loaded. N is 2 for force, 1 for torque, 3 for
//   a linear impulse, 7 for an offset impulse, 10 for an update, 2 when the
//   body is static and 1 for an unused kind. Result valid rises as the core
//   returns to idle, ready for the next word.
//   The dependent multiply chain of the update sets its length.
// Reset: inverse mass and inertia 1.0, body and force state zero, no result pending.
// Stall: a result waits in its output register; the core then runs one more
//   word and holds it complete until the register frees.

module rigid_body_euler_step_core import rbes_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    rbes_in_if.sink              items,
    rbes_out_if.source           results
);

    seq_ctl_t ctl;
    logic     stat;
    result_t  res;

    rbes_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .in_kind   (items.kind),
        .out_ready (results.ready),
        .out_valid (results.valid),
        .stat      (stat),
        .ctl       (ctl)
    );

    rbes_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ctl          (ctl),
        .vec_x        (items.vec_x),
        .vec_y        (items.vec_y),
        .torque_value (items.torque_value),
        .arm_x        (items.arm_x),
        .arm_y        (items.arm_y),
        .step_time    (items.step_time),
        .stat         (stat),
        .res          (res)
    );

    assign results.pos_x     = res.pos_x;
    assign results.pos_y     = res.pos_y;
    assign results.angle     = res.angle;
    assign results.vel_x     = res.vel_x;
    assign results.vel_y     = res.vel_y;
    assign results.spin      = res.spin;
    assign results.is_static = res.is_static;

endmodule
